// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the hit finder RTL.
// The including module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every edge outside reset.
`define FHF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, expr holds in the same cycle.
`define FHF_ASSERT_NOW(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// When cond holds, expr holds in the next cycle.
`define FHF_ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/fhf_pkg.sv =====
// ----------------------------------------------------------------------------
// fhf_pkg
// Widths, constants and the event record shared by the hit finder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhf_pkg;

  localparam int PIXEL_W  = 16;
  localparam int SQ_W     = 31;  // pixel squared, at most 2^30
  localparam int SUM_W    = 37;
  localparam int SUMSQ_W  = 52;
  localparam int COUNT_W  = 22;
  localparam int THR_W    = 31;
  localparam int NN_W     = 2 * COUNT_W;
  localparam int MCAND_W  = 52;  // widest multiplicand: sum of squares
  localparam int MPLIER_W = 43;  // serial operand width; widest operand used is |sum|
  localparam int PROD_W   = 74;

  localparam logic [COUNT_W-1:0] MAX_PIXELS        = 22'd2097152;
  localparam logic [THR_W-1:0]   DEFAULT_THRESHOLD = 31'd1000;

  // APB register map
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SUMSQ_W-1:0]      sumsq;
    logic [COUNT_W-1:0]      count;
  } event_t;

endpackage

// ===== hw/rtl/frame_hit_finder_sum_variance.sv =====
// ----------------------------------------------------------------------------
// frame_hit_finder_sum_variance
// Per-event pixel sum and population variance hit finder.
//
// Pixel beats enter on push/full, one per cycle while full is low, with
// last_pixel on the final pixel of an event. Each event yields one result
// beat on empty/pop: integral, pixel_count and the hit verdict with its two
// reasons. Pixels past 2^21 in one event are dropped; the last flag still
// closes the event. The variance test is exact: n*sumsq - sum^2 <
// threshold*n^2 sets low_spread. variance_threshold sits at APB address 0
// (reset 1000); write it only while no event is in flight.
// The time from the last pixel beat to its result grows with the bit length
// of |sum| or of threshold or of the count, whichever is longest. The verdict
// stage handles one event at a time, paced by the bit-serial multipliers (one
// bit a cycle); a two-entry event queue lets pixel intake run ahead meanwhile.
// When the result is not popped, the queue fills and full rises on the next
// last pixel. Reset clears the accumulators, the queue and the result valid flag, and
// restores the threshold to 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_hit_finder_sum_variance (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [fhf_pkg::PIXEL_W-1:0]    pixel,
  input  logic                                  last_pixel,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  is_hit,
  output logic signed [fhf_pkg::SUM_W-1:0]      integral,
  output logic [fhf_pkg::COUNT_W-1:0]           pixel_count,
  output logic                                  negative_signal,
  output logic                                  low_spread,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fhf_pkg::PADDR_W-1:0]           paddr,
  input  logic [fhf_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [fhf_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  logic [fhf_pkg::THR_W-1:0] threshold;
  logic                      reg_sel;

  logic                      q_push;
  fhf_pkg::event_t           q_in;
  logic                      q_full;
  logic                      q_pop;
  fhf_pkg::event_t           q_out;
  logic                      q_empty;

  assign pready  = 1'b1;
  assign reg_sel = paddr[fhf_pkg::PADDR_W-1:2] == fhf_pkg::REG_THRESHOLD;
  assign prdata  = reg_sel ? fhf_pkg::APB_DATA_W'(threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fhf_pkg::DEFAULT_THRESHOLD;
    end else if (psel && penable && pwrite && reg_sel) begin
      threshold <= pwdata[fhf_pkg::THR_W-1:0];
    end
  end

  fhf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .pixel      (pixel),
    .last_pixel (last_pixel),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  fhf_event_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  fhf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (q_out),
    .threshold       (threshold),
    .empty           (empty),
    .pop             (pop),
    .is_hit          (is_hit),
    .integral        (integral),
    .pixel_count     (pixel_count),
    .negative_signal (negative_signal),
    .low_spread      (low_spread)
  );

endmodule

// ===== hw/rtl/fhf_front.sv =====
// ----------------------------------------------------------------------------
// fhf_front
// Takes pixel beats, squares them, and keeps the running sum, sum of squares
// and count. The last pixel of an event hands the totals to the event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fhf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [fhf_pkg::PIXEL_W-1:0]  pixel,
  input  logic                                last_pixel,
  output logic                                q_push,
  output fhf_pkg::event_t                     q_data,
  input  logic                                q_full
);

  logic                               s1_valid;
  logic signed [fhf_pkg::PIXEL_W-1:0] s1_px;
  logic [fhf_pkg::SQ_W-1:0]           s1_sq;
  logic                               s1_last;

  logic signed [fhf_pkg::SUM_W-1:0]   acc_sum;
  logic [fhf_pkg::SUMSQ_W-1:0]        acc_sumsq;
  logic [fhf_pkg::COUNT_W-1:0]        acc_count;

  logic signed [2*fhf_pkg::PIXEL_W-1:0] sq_full;
  logic                               stall;
  logic                               accept;
  logic                               advance;
  logic                               room;
  logic signed [fhf_pkg::SUM_W-1:0]   sum_next;
  logic [fhf_pkg::SUMSQ_W-1:0]        sumsq_next;
  logic [fhf_pkg::COUNT_W-1:0]        count_next;

  assign sq_full = pixel * pixel;

  // a last pixel waits in stage 1 while the queue is full
  assign stall   = s1_valid & s1_last & q_full;
  assign full    = stall;
  assign accept  = push & ~stall;
  assign advance = s1_valid & ~stall;

  // pixels past the limit are dropped, a last flag still closes the event
  assign room       = acc_count < fhf_pkg::MAX_PIXELS;
  assign sum_next   = room ? acc_sum + fhf_pkg::SUM_W'(s1_px) : acc_sum;
  assign sumsq_next = room ? acc_sumsq + fhf_pkg::SUMSQ_W'(s1_sq) : acc_sumsq;
  assign count_next = room ? acc_count + 1'b1 : acc_count;

  assign q_push       = advance & s1_last;
  assign q_data.sum   = sum_next;
  assign q_data.sumsq = sumsq_next;
  assign q_data.count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel;
      s1_sq   <= sq_full[fhf_pkg::SQ_W-1:0];
      s1_last <= last_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum   <= '0;
      acc_sumsq <= '0;
      acc_count <= '0;
    end else if (advance) begin
      if (s1_last) begin
        acc_sum   <= '0;
        acc_sumsq <= '0;
        acc_count <= '0;
      end else begin
        acc_sum   <= sum_next;
        acc_sumsq <= sumsq_next;
        acc_count <= count_next;
      end
    end
  end

  `FHF_ASSERT(a_count_bound, acc_count <= fhf_pkg::MAX_PIXELS, "pixel count past limit")

endmodule

// ===== hw/rtl/fhf_event_queue.sv =====
// ----------------------------------------------------------------------------
// fhf_event_queue
// Two-entry queue of finished event totals between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fhf_event_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fhf_pkg::event_t push_data,
  output logic            full,
  input  logic            pop,
  output fhf_pkg::event_t pop_data,
  output logic            empty
);

  fhf_pkg::event_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            do_push;
  logic            do_pop;

  assign full     = fill == 2'd2;
  assign empty    = fill == 2'd0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `FHF_ASSERT_NOW(a_no_overflow, push, !full, "event pushed into full queue")

endmodule

// ===== hw/rtl/fhf_serial_mul.sv =====
// ----------------------------------------------------------------------------
// fhf_serial_mul
// Shift-add multiplier, one multiplier bit per cycle. Stops as soon as the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhf_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fhf_pkg::MCAND_W-1:0]   mcand,
  input  logic [fhf_pkg::MPLIER_W-1:0]  mplier,
  output logic                          busy,
  output logic [fhf_pkg::PROD_W-1:0]    product
);

  logic [fhf_pkg::PROD_W-1:0]   mc;
  logic [fhf_pkg::MPLIER_W-1:0] mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy) begin
      busy <= mp[fhf_pkg::MPLIER_W-1:1] != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc      <= fhf_pkg::PROD_W'(mcand);
      mp      <= mplier;
      product <= '0;
    end else if (busy) begin
      if (mp[0]) begin
        product <= product + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

endmodule

// ===== hw/rtl/fhf_back.sv =====
// ----------------------------------------------------------------------------
// fhf_back
// Takes event totals from the queue, forms count*sumsq, sum^2 and
// threshold*count^2 with three serial multipliers, compares, and holds the
// verdict in the result register until it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fhf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  fhf_pkg::event_t                     q_data,
  input  logic [fhf_pkg::THR_W-1:0]           threshold,
  output logic                                empty,
  input  logic                                pop,
  output logic                                is_hit,
  output logic signed [fhf_pkg::SUM_W-1:0]    integral,
  output logic [fhf_pkg::COUNT_W-1:0]         pixel_count,
  output logic                                negative_signal,
  output logic                                low_spread
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                         state;
  logic [2:0]                         state_next;

  logic signed [fhf_pkg::SUM_W-1:0]   ev_sum;
  logic [fhf_pkg::SUM_W-1:0]          ev_mag;
  logic [fhf_pkg::SUMSQ_W-1:0]        ev_sumsq;
  logic [fhf_pkg::COUNT_W-1:0]        ev_count;
  logic [fhf_pkg::NN_W-1:0]           nn;
  logic [fhf_pkg::PROD_W-1:0]         spread;

  logic                               mul_start;
  logic                               busy_nsq;
  logic                               busy_ssq;
  logic                               busy_thr;
  logic [fhf_pkg::PROD_W-1:0]         p_nsq;
  logic [fhf_pkg::PROD_W-1:0]         p_ssq;
  logic [fhf_pkg::PROD_W-1:0]         p_thr;

  logic                               res_valid;
  logic                               res_write;
  logic                               low;
  logic                               neg;

  assign q_pop     = (state == ST_IDLE) & ~q_empty;
  assign mul_start = state == ST_START;
  assign nn        = ev_count * ev_count;

  fhf_serial_mul u_mul_nsq (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (ev_sumsq),
    .mplier  (fhf_pkg::MPLIER_W'(ev_count)),
    .busy    (busy_nsq),
    .product (p_nsq)
  );

  fhf_serial_mul u_mul_ssq (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (fhf_pkg::MCAND_W'(ev_mag)),
    .mplier  (fhf_pkg::MPLIER_W'(ev_mag)),
    .busy    (busy_ssq),
    .product (p_ssq)
  );

  fhf_serial_mul u_mul_thr (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (fhf_pkg::MCAND_W'(nn)),
    .mplier  (fhf_pkg::MPLIER_W'(threshold)),
    .busy    (busy_thr),
    .product (p_thr)
  );

  assign low       = spread < p_thr;
  assign neg       = ev_sum[fhf_pkg::SUM_W-1];
  assign res_write = (state == ST_DONE) & (~res_valid | pop);
  assign empty     = ~res_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (!busy_nsq && !busy_ssq && !busy_thr) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_write) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_sum   <= q_data.sum;
      ev_sumsq <= q_data.sumsq;
      ev_count <= q_data.count;
      ev_mag   <= q_data.sum[fhf_pkg::SUM_W-1] ? fhf_pkg::SUM_W'(-q_data.sum)
                                               : fhf_pkg::SUM_W'(q_data.sum);
    end
    if (state == ST_DIFF) begin
      spread <= p_nsq - p_ssq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_write) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      is_hit          <= ~neg & ~low;
      integral        <= ev_sum;
      pixel_count     <= ev_count;
      negative_signal <= neg;
      low_spread      <= low;
    end
  end

  // n*sumsq >= sum^2 for any set of integers
  `FHF_ASSERT_NOW(a_spread_nonneg, state == ST_DIFF, p_nsq >= p_ssq, "negative spread")
  `FHF_ASSERT_NEXT(a_result_held, res_valid && !pop, res_valid, "result beat lost")

endmodule

// ===== tb/frame_hit_finder_sum_variance_test.sv =====
// ----------------------------------------------------------------------------
// frame_hit_finder_sum_variance_test
// Self-checking bench for the per-event sum/variance hit finder.
//
// A queue of pixel beats feeds a falling-edge driver. The accepted beats go
// through a local model of the accumulators and the exact integer variance
// test. Each result beat popped from the block is compared, field by field,
// against the oldest predicted verdict. The threshold register is written and
// read back over APB between phases. The phases cover reset, zero, maximum and
// random thresholds and an unmapped address, and a long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_hit_finder_sum_variance_test;

  localparam logic [0:0] REG_UNMAPPED = 1'b1;
  localparam int         PENDING_MAX  = 16;
  localparam int         SETTLE_CYC   = 60;   // covers the worst verdict latency

  typedef struct {
    logic signed [fhf_pkg::PIXEL_W-1:0] value;
    logic                               last;
  } pixel_beat_t;

  typedef struct {
    logic                        hit;
    logic [fhf_pkg::SUM_W-1:0]   integral;
    logic [fhf_pkg::COUNT_W-1:0] count;
    logic                        negative;
    logic                        low;
  } verdict_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               push = 1'b0;
  logic                               full;
  logic signed [fhf_pkg::PIXEL_W-1:0] pixel = '0;
  logic                               last_pixel = 1'b0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic                               is_hit;
  logic signed [fhf_pkg::SUM_W-1:0]   integral;
  logic [fhf_pkg::COUNT_W-1:0]        pixel_count;
  logic                               negative_signal;
  logic                               low_spread;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [fhf_pkg::PADDR_W-1:0]        paddr = '0;
  logic [fhf_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [fhf_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  frame_hit_finder_sum_variance dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .pixel(pixel), .last_pixel(last_pixel),
    .empty(empty), .pop(pop), .is_hit(is_hit), .integral(integral),
    .pixel_count(pixel_count), .negative_signal(negative_signal),
    .low_spread(low_spread),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  pixel_beat_t pixels_pending[$];
  verdict_t    verdicts_due[$];
  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold = 1'b0;
  event        long_stall;

  // model state
  longint                      ev_sum = 0;
  longint                      ev_sumsq = 0;
  logic [fhf_pkg::COUNT_W-1:0] ev_count = '0;
  logic [fhf_pkg::THR_W-1:0]   threshold_model = fhf_pkg::DEFAULT_THRESHOLD;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic accumulate_pixel(input logic signed [fhf_pkg::PIXEL_W-1:0] px,
                                  input logic last);
    logic [127:0] n_w, sq_w, mag_w, thr_w, spread, floor_v;
    longint       pxl, mag;
    verdict_t     v;
    pxl = px;
    if (ev_count < fhf_pkg::MAX_PIXELS) begin
      ev_sum   = ev_sum + pxl;
      ev_sumsq = ev_sumsq + pxl * pxl;
      ev_count = ev_count + 1'b1;
    end
    if (last) begin
      mag     = (ev_sum < 0) ? -ev_sum : ev_sum;
      n_w     = 128'(ev_count);
      sq_w    = 128'(ev_sumsq);
      mag_w   = 128'(mag);
      thr_w   = 128'(threshold_model);
      spread  = n_w * sq_w - mag_w * mag_w;
      floor_v = thr_w * (n_w * n_w);
      v.negative = ev_sum < 0;
      v.low      = spread < floor_v;
      v.hit      = !v.negative && !v.low;
      v.integral = ev_sum[fhf_pkg::SUM_W-1:0];
      v.count    = ev_count;
      verdicts_due.push_back(v);
      ev_sum   = 0;
      ev_sumsq = 0;
      ev_count = '0;
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (pixels_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        push       <= 1'b1;
        pixel      <= pixels_pending[0].value;
        last_pixel <= pixels_pending[0].last;
      end else begin
        push <= 1'b0;
      end
      pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: beats are taken at the rising edge
  always @(posedge clk) begin
    verdict_t v;
    if (!rst) begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result beat with no event closed", pixel_count, 0);
        end else begin
          v = verdicts_due.pop_front();
          if (is_hit !== v.hit) report_mismatch("is_hit", is_hit, v.hit);
          if (integral !== v.integral)
            report_mismatch("integral", $signed(integral), $signed(v.integral));
          if (pixel_count !== v.count) report_mismatch("pixel_count", pixel_count, v.count);
          if (negative_signal !== v.negative)
            report_mismatch("negative_signal", negative_signal, v.negative);
          if (low_spread !== v.low) report_mismatch("low_spread", low_spread, v.low);
        end
      end
      if (push && !full && pixels_pending.size() > 0) begin
        accumulate_pixel(pixel, last_pixel);
        void'(pixels_pending.pop_front());
      end
    end
  end

  // receiver hold-off, counted here so the sender keeps going meanwhile
  always begin
    @(long_stall);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (500) @(negedge clk);
    rx_hold <= 1'b0;
  end

  task automatic offer_pixel(input int v, input logic last);
    pixel_beat_t b;
    while (pixels_pending.size() >= PENDING_MAX) @(posedge clk);
    b.value = v[fhf_pkg::PIXEL_W-1:0];
    b.last  = last;
    pixels_pending.push_back(b);
  endtask

  task automatic wait_drained();
    while (pixels_pending.size() > 0 || verdicts_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_write(input logic [0:0] reg_idx,
                           input logic [fhf_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == fhf_pkg::REG_THRESHOLD) threshold_model = data[fhf_pkg::THR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_threshold();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {fhf_pkg::REG_THRESHOLD, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {1'b0, threshold_model})
      report_mismatch("threshold readback", prdata, threshold_model);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int clamp_pixel(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // events of random length and flavor until the pixel budget is spent
  task automatic random_events(input int budget);
    int len, flavor, base, amp, v, r, i;
    while (budget > 0) begin
      len    = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      flavor = $urandom_range(3);
      r      = $urandom_range(65535);
      base   = r - 32768;
      amp    = (flavor == 1) ? $urandom_range(40) : $urandom_range(4000);
      for (i = 0; i < len; i++) begin
        case (flavor)
          0: begin
            r = $urandom_range(65535);
            v = r - 32768;
          end
          2: begin
            case ($urandom_range(4))
              0: v = -32768;
              1: v = 32767;
              2: v = 0;
              3: v = -1;
              default: v = 1;
            endcase
          end
          default: begin
            r = $urandom_range(2 * amp);
            v = clamp_pixel(base + r - amp);
          end
        endcase
        offer_pixel(v, i == len - 1);
      end
      budget -= len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset threshold, directed events
    tx_idle_pct = 20;
    rx_idle_pct = 53;
    apb_check_threshold();
    offer_pixel(32767, 1'b1);
    offer_pixel(-32768, 1'b1);
    offer_pixel(32767, 1'b0);
    offer_pixel(-32768, 1'b1);          // integral -1
    offer_pixel(0, 1'b0);
    offer_pixel(0, 1'b0);
    offer_pixel(0, 1'b1);               // flat, zero integral
    offer_pixel(-1, 1'b0);
    offer_pixel(1, 1'b1);               // variance just 1
    offer_pixel(1000, 1'b0);
    offer_pixel(-100, 1'b0);
    offer_pixel(500, 1'b0);
    offer_pixel(2000, 1'b1);            // clear hit
    offer_pixel(-5000, 1'b0);
    offer_pixel(5000, 1'b0);
    offer_pixel(-4000, 1'b1);           // wide spread but negative
    offer_pixel(100, 1'b0);
    offer_pixel(100, 1'b1);             // positive, no spread
    random_events(250);
    wait_drained();

    // zero threshold; unmapped write must not touch it
    tx_idle_pct = 53;
    rx_idle_pct = 20;
    apb_write(REG_UNMAPPED, $urandom());
    apb_check_threshold();
    apb_write(fhf_pkg::REG_THRESHOLD, 32'd0);
    apb_check_threshold();
    -> long_stall;
    random_events(150);
    wait_drained();

    // all ones: bit 31 is dropped
    apb_write(fhf_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
    apb_check_threshold();
    random_events(150);
    wait_drained();

    // threshold near the spread of the random events, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apb_write(fhf_pkg::REG_THRESHOLD, $urandom_range(1, 3_000_000));
    apb_check_threshold();
    random_events(200);
    wait_drained();

    if (verdicts_due.size() > 0) report_mismatch("results never seen", 0, verdicts_due.size());
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
